[hw/rtl/pngsu_pkg.sv]
// shared types and constants for the png scanline unfilter
package pngsu_pkg;

  localparam int unsigned ROW_BYTES_W       = 14;
  localparam int unsigned PIXEL_BYTES_W     = 4;
  localparam int unsigned CFG_DATA_W        = 14;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned DEF_MAX_ROW_BYTES   = 8192;
  localparam int unsigned DEF_MAX_PIXEL_BYTES = 8;

  localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RST   = ROW_BYTES_W'(1);
  localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = PIXEL_BYTES_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_BYTES   = 1'b0,
    CFG_PIXEL_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_last;
    logic       bad_filter;
  } out_word_t;

endpackage

[hw/rtl/png_scanline_unfilter.sv]
// png scanline filter reconstruction: none, sub, up, average and paeth
// a data word passes the input stage register, then the result register, where it may stall
// throughput: one word per cycle while the output is not stalled, set by the single line store read per word
// filter type words give no result unless the type is unknown (then an error word)
// reset clears control state and config to defaults; the line store is not cleared,
// the first row of each image ignores what it reads from it
module png_scanline_unfilter
  import pngsu_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int unsigned MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW    = $clog2(MAX_ROW_BYTES);
  localparam int unsigned SW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int unsigned CMP_W = (CW + 1 > ROW_BYTES_W) ? CW + 1 : ROW_BYTES_W;

  typedef struct packed {
    logic [7:0]    data_byte;
    filt_e         filter;
    logic [CW-1:0] col;
    logic [SW-1:0] slot;
    logic          col_ge_pb;
    logic          first;
    logic          last;
    logic          bad;
  } s1_t;

  logic [ROW_BYTES_W-1:0]   row_bytes_q;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes_q;

  logic [CW-1:0] column_q, column_d;
  logic          awaiting_q, awaiting_d;
  logic          first_q, first_d;
  logic          halted_q, halted_d;
  filt_e         filter_q, filter_d;

  // column modulo every pixel size, so a slot follows the current size
  logic [SW-1:0] mod_q [MAX_PIXEL_BYTES];
  logic [SW-1:0] slot;
  logic          col_clr, col_inc;

  logic          s1_valid_q, s1_valid_d;
  s1_t           s1_q;
  logic          s1_adv;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_data_q;

  logic          in_acc, push, push_bad, clr_ring, rd_en;
  logic          start, halted_eff, awaiting_eff, last;
  logic [CMP_W-1:0]         col_nxt;
  logic [PIXEL_BYTES_W-1:0] pb_eff;
  logic                     col_ge_pb;

  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_q, fwd_data_q;
  logic       fwd_q;
  logic       mem_we;

  logic [7:0]                 left_q [MAX_PIXEL_BYTES];
  logic [7:0]                 ul_q   [MAX_PIXEL_BYTES];
  logic [MAX_PIXEL_BYTES-1:0] ring_vld_q;

  logic [7:0]  a, b, c, upper, pred, recon;
  logic [8:0]  sum_ab;
  logic signed [10:0] da, db, dc;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= ROW_BYTES_RST;
      pixel_bytes_q <= PIXEL_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_BYTES:   row_bytes_q   <= cfg_wdata_i[ROW_BYTES_W-1:0];
        CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_wdata_i[PIXEL_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    if (pixel_bytes_q == '0) begin
      pb_eff = PIXEL_BYTES_W'(1);
    end else if (pixel_bytes_q > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
      pb_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pixel_bytes_q;
    end
  end

  assign col_nxt   = CMP_W'(column_q) + CMP_W'(1);
  assign last      = (col_nxt >= CMP_W'(row_bytes_q)) || (col_nxt >= CMP_W'(MAX_ROW_BYTES));
  assign col_ge_pb = CMP_W'(column_q) >= CMP_W'(pb_eff);
  assign slot      = mod_q[SW'(pb_eff - PIXEL_BYTES_W'(1))];

  assign start        = in_data_i.image_start;
  assign halted_eff   = halted_q && !start;
  assign awaiting_eff = awaiting_q || start;

  // row and column tracking, decided at accept
  always_comb begin
    column_d   = column_q;
    awaiting_d = awaiting_q;
    first_d    = first_q;
    halted_d   = halted_q;
    filter_d   = filter_q;
    col_clr    = 1'b0;
    col_inc    = 1'b0;
    push       = 1'b0;
    push_bad   = 1'b0;
    clr_ring   = 1'b0;
    rd_en      = 1'b0;
    if (in_acc) begin
      if (start) begin
        column_d   = '0;
        col_clr    = 1'b1;
        awaiting_d = 1'b1;
        first_d    = 1'b1;
        halted_d   = 1'b0;
        clr_ring   = 1'b1;
      end
      if (!halted_eff) begin
        if (awaiting_eff) begin
          if (in_data_i.data_byte > 8'(FILT_PAETH)) begin
            halted_d = 1'b1;
            push     = 1'b1;
            push_bad = 1'b1;
          end else begin
            filter_d   = filt_e'(in_data_i.data_byte[2:0]);
            awaiting_d = 1'b0;
            column_d   = '0;
            col_clr    = 1'b1;
            clr_ring   = 1'b1;
          end
        end else begin
          push  = 1'b1;
          rd_en = 1'b1;
          if (last) begin
            column_d   = '0;
            col_clr    = 1'b1;
            awaiting_d = 1'b1;
            first_d    = 1'b0;
          end else begin
            column_d = column_q + CW'(1);
            col_inc  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q   <= '0;
      awaiting_q <= 1'b1;
      first_q    <= 1'b1;
      halted_q   <= 1'b0;
      filter_q   <= FILT_NONE;
    end else begin
      column_q   <= column_d;
      awaiting_q <= awaiting_d;
      first_q    <= first_d;
      halted_q   <= halted_d;
      filter_q   <= filter_d;
    end
  end

  for (genvar g = 0; g < MAX_PIXEL_BYTES; g++) begin : g_mod
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mod_q[g] <= '0;
      end else if (col_clr) begin
        mod_q[g] <= '0;
      end else if (col_inc) begin
        mod_q[g] <= (mod_q[g] == SW'(g)) ? '0 : mod_q[g] + SW'(1);
      end
    end
  end

  // input stage
  assign s1_valid_d = push ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_q.data_byte <= in_data_i.data_byte;
      s1_q.filter    <= filter_q;
      s1_q.col       <= column_q;
      s1_q.slot      <= slot;
      s1_q.col_ge_pb <= col_ge_pb;
      s1_q.first     <= first_q;
      s1_q.last      <= last;
      s1_q.bad       <= push_bad;
    end
  end

  // line store, with forwarding when a row of one byte reads what is being written
  assign mem_we = s1_adv && !s1_q.bad;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_q.col] <= recon;
    end
    if (rd_en) begin
      rd_data_q  <= mem[column_q];
      fwd_q      <= mem_we && (s1_q.col == column_q);
      fwd_data_q <= recon;
    end
  end

  assign upper = fwd_q ? fwd_data_q : rd_data_q;

  // left and upper-left rings
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      left_q[s1_q.slot] <= recon;
      ul_q[s1_q.slot]   <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
    end else if (clr_ring) begin
      ring_vld_q <= '0;
    end else if (mem_we) begin
      ring_vld_q[s1_q.slot] <= 1'b1;
    end
  end

  // predictor
  assign a = (s1_q.col_ge_pb && ring_vld_q[s1_q.slot]) ? left_q[s1_q.slot] : 8'd0;
  assign b = s1_q.first ? 8'd0 : upper;
  assign c = (s1_q.col_ge_pb && !s1_q.first && ring_vld_q[s1_q.slot]) ?
             ul_q[s1_q.slot] : 8'd0;

  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({2'b00, sum_ab}) - $signed({2'b00, c, 1'b0});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
  end

  always_comb begin
    case (s1_q.filter)
      FILT_NONE: pred = 8'd0;
      FILT_SUB:  pred = a;
      FILT_UP:   pred = b;
      FILT_AVG:  pred = sum_ab[8:1];
      FILT_PAETH: begin
        if (da <= db && da <= dc) begin
          pred = a;
        end else if (db <= dc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:   pred = 8'd0;
    endcase
  end

  assign recon = s1_q.data_byte + pred;

  // result register
  assign out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q.pixel_byte <= s1_q.bad ? 8'd0 : recon;
      out_data_q.row_last   <= s1_q.bad ? 1'b0 : s1_q.last;
      out_data_q.bad_filter <= s1_q.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input stage word dropped while stalled");

  a_bad_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_bad |=> halted_q)
    else $error("error word without halt");

  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (column_q == '0) && (slot == '0))
    else $error("column not at row start while awaiting type");

  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.bad_filter |->
      (out_data_q.pixel_byte == 8'd0) && !out_data_q.row_last)
    else $error("error word carries pixel data");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && in_acc && !in_data_i.image_start |-> !push)
    else $error("word produced while halted");
`endif

endmodule

[tb/tb_top.sv]
// testbench for png_scanline_unfilter: directed and random images checked against a byte predictor
module tb_top;
  import pngsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROW   = DEF_MAX_ROW_BYTES;
  localparam int unsigned MAX_PIX   = DEF_MAX_PIXEL_BYTES;
  localparam int unsigned CI_W      = $clog2(MAX_ROW);
  localparam int unsigned SI_W      = $clog2(MAX_PIX);
  localparam int unsigned LIMIT     = 1000000;
  localparam int unsigned RAND_WORDS = 1200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_word_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_word_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  png_scanline_unfilter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  logic [7:0]              line_mem [MAX_ROW];
  logic [7:0]              left_ring [MAX_PIX];
  logic [7:0]              upleft_ring [MAX_PIX];
  int unsigned             col;
  bit                      need_type;
  filt_e                   filt;
  bit                      first_row;
  bit                      stopped;
  logic [ROW_BYTES_W-1:0]  row_reg;
  logic [PIXEL_BYTES_W-1:0] pix_reg;

  out_word_t   pending_words [$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned words_sent;
  bit          idle_on;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic clear_rings();
    left_ring   = '{default: 8'h00};
    upleft_ring = '{default: 8'h00};
  endtask

  task automatic rebuild_byte(input in_word_t w);
    out_word_t       r;
    int unsigned     rb, pb, slot;
    logic [7:0]      a, b, c, pred, recon;
    logic [CI_W-1:0] ci;
    logic [SI_W-1:0] si;
    bit              last;
    if (w.image_start) begin
      col       = 0;
      need_type = 1'b1;
      first_row = 1'b1;
      stopped   = 1'b0;
      clear_rings();
    end
    if (stopped) return;
    if (need_type) begin
      if (w.data_byte > 8'd4) begin
        stopped = 1'b1;
        r.pixel_byte = 8'h00;
        r.row_last   = 1'b0;
        r.bad_filter = 1'b1;
        pending_words.push_back(r);
        return;
      end
      filt      = filt_e'(w.data_byte[2:0]);
      need_type = 1'b0;
      col       = 0;
      clear_rings();
      return;
    end
    rb = 32'(row_reg);
    if (rb < 1) rb = 1;
    if (rb > MAX_ROW) rb = MAX_ROW;
    pb = 32'(pix_reg);
    if (pb < 1) pb = 1;
    if (pb > MAX_PIX) pb = MAX_PIX;
    slot = col % pb;
    ci   = CI_W'(col);
    si   = SI_W'(slot);
    a = (col >= pb) ? left_ring[si] : 8'h00;
    b = first_row ? 8'h00 : line_mem[ci];
    c = (col >= pb && !first_row) ? upleft_ring[si] : 8'h00;
    case (filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'h00;
    endcase
    recon = w.data_byte + pred;
    upleft_ring[si] = b;
    left_ring[si]   = recon;
    line_mem[ci]    = recon;
    last = (col + 1 >= rb);
    if (last) begin
      col       = 0;
      need_type = 1'b1;
      first_row = 1'b0;
    end else begin
      col++;
    end
    r.pixel_byte = recon;
    r.row_last   = last;
    r.bad_filter = 1'b0;
    pending_words.push_back(r);
  endtask

  always @(posedge clk_i) begin
    out_word_t e;
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               pending_words.size());
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROW_BYTES) row_reg = cfg_wdata_i[ROW_BYTES_W-1:0];
        else pix_reg = cfg_wdata_i[PIXEL_BYTES_W-1:0];
      end
      if (in_valid_i && in_ready_o) rebuild_byte(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: pixel %02h last %b bad %b", out_data_o.pixel_byte,
                     out_data_o.row_last, out_data_o.bad_filter);
        end else begin
          e = pending_words.pop_front();
          if (out_data_o.pixel_byte !== e.pixel_byte || out_data_o.row_last !== e.row_last ||
              out_data_o.bad_filter !== e.bad_filter) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected pixel %02h last %b bad %b, got %02h %b %b",
                       e.pixel_byte, e.row_last, e.bad_filter, out_data_o.pixel_byte,
                       out_data_o.row_last, out_data_o.bad_filter);
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(5, 0) : 0;
      repeat (stall) begin
        out_ready_i <= 1'b0;
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [7:0] b, input logic s);
    int gap;
    gap = idle_on ? $urandom_range(5, 0) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_i.data_byte   <= b;
    in_data_i.image_start <= s;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_row(input logic [7:0] ftype, input logic start, input int n);
    send_word(ftype, start);
    for (int i = 0; i < n; i++) send_word(8'($urandom), 1'b0);
  endtask

  task automatic test_reset_defaults();
    send_word(8'(FILT_SUB), 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'(FILT_UP), 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'(FILT_PAETH), 1'b0);
    send_word(8'hff, 1'b0);
  endtask

  task automatic test_each_filter();
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(4));
    write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'(2));
    send_word(8'(FILT_NONE), 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_row(8'(FILT_SUB), 1'b0, 4);
    send_row(8'(FILT_UP), 1'b0, 4);
    send_row(8'(FILT_AVG), 1'b0, 4);
    send_row(8'(FILT_PAETH), 1'b0, 4);
  endtask

  task automatic test_bad_filter();
    send_word(8'd5, 1'b1);
    send_word(8'h12, 1'b0);
    send_word(8'(FILT_NONE), 1'b0);
    send_word(8'hff, 1'b1);
    send_row(8'(FILT_PAETH), 1'b1, 4);
    send_word(8'd7, 1'b0);
    send_word(8'h34, 1'b0);
  endtask

  task automatic test_start_mid_row();
    send_row(8'(FILT_UP), 1'b1, 4);
    send_row(8'(FILT_AVG), 1'b0, 2);
    send_row(8'(FILT_SUB), 1'b1, 4);
    send_row(8'(FILT_PAETH), 1'b0, 4);
  endtask

  task automatic test_register_clamps();
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(0));
    write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'(0));
    send_row(8'(FILT_SUB), 1'b1, 1);
    send_row(8'(FILT_PAETH), 1'b0, 1);
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(12));
    write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'(15));
    send_row(8'(FILT_SUB), 1'b1, 12);
    send_row(8'(FILT_PAETH), 1'b0, 12);
    send_row(8'(FILT_AVG), 1'b0, 12);
  endtask

  task automatic test_row_changes();
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(8));
    write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'(3));
    send_row(8'(FILT_SUB), 1'b1, 8);
    send_row(8'(FILT_PAETH), 1'b0, 3);
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(5));
    send_word(8'h5a, 1'b0);
    send_word(8'ha5, 1'b0);
    send_row(8'(FILT_AVG), 1'b0, 2);
    write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'(2));
    for (int i = 0; i < 3; i++) send_word(8'($urandom), 1'b0);
    send_row(8'(FILT_NONE), 1'b0, 2);
    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(2));
    send_word(8'h3c, 1'b0);
    send_row(8'(FILT_UP), 1'b0, 2);
  endtask

  task automatic test_random_images();
    int unsigned start_cnt, nrows, nrb, sel;
    bit          fresh;
    logic [7:0]  ftype;
    start_cnt = words_sent;
    nrb = 1;
    while (words_sent - start_cnt < RAND_WORDS) begin
      fresh = 1'b0;
      if ($urandom_range(3, 0) == 0) begin
        sel = $urandom_range(19, 0);
        if (sel < 13) nrb = $urandom_range(8, 1);
        else if (sel < 18) nrb = $urandom_range(40, 9);
        else nrb = 0;
        write_reg(CFG_ROW_BYTES, CFG_DATA_W'(nrb));
        if ($urandom_range(3, 0) == 0)
          write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'($urandom_range(15, 0)));
        else write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'($urandom_range(8, 1)));
        fresh = 1'b1;
      end
      idle_on = ($urandom_range(4, 0) != 0);
      nrows = $urandom_range(4, 1);
      for (int r = 0; r < nrows; r++) begin
        if ($urandom_range(19, 0) == 0) ftype = 8'($urandom_range(255, 5));
        else ftype = 8'($urandom_range(4, 0));
        send_row(ftype, (r == 0) && (fresh || $urandom_range(1, 0) == 1),
                 (nrb == 0) ? 1 : nrb);
      end
      if ($urandom_range(7, 0) == 0) begin
        for (int i = $urandom_range(6, 1); i > 0; i--)
          send_word(8'($urandom), 1'($urandom_range(1, 0)));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    words_sent   = 0;
    idle_on      = 1'b1;
    row_reg      = ROW_BYTES_RST;
    pix_reg      = PIXEL_BYTES_RST;
    col          = 0;
    need_type    = 1'b1;
    filt         = FILT_NONE;
    first_row    = 1'b1;
    stopped      = 1'b0;
    clear_rings();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_each_filter();
    test_bad_filter();
    test_start_mid_row();
    test_register_clamps();
    test_row_changes();
    test_random_images();

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
